// File: rtl/nd_grid_neighbour_enumerator_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the grid neighbour enumerator
// Same-cycle and next-cycle implication checks, clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef ND_GRID_NEIGHBOUR_ENUMERATOR_TOP_DEFINES_SVH
`define ND_GRID_NEIGHBOUR_ENUMERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define NDGN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define NDGN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define NDGN_ASSERT_IMPL(lbl, ante, cons)
`define NDGN_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/ndgn_pkg.sv
// ---------------------------------------------------------------------------
// ndgn_pkg
// Register map, widths and reset values of the grid neighbour enumerator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ndgn_pkg;

  localparam int unsigned CUM_W      = 25;
  localparam int unsigned DIMC_W     = 3;
  localparam int unsigned NUM_CUM    = 4;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DIM_COUNT = 3'd0,
    REG_CUM_0     = 3'd1,
    REG_CUM_1     = 3'd2,
    REG_CUM_2     = 3'd3,
    REG_CUM_3     = 3'd4
  } reg_idx_e;

  localparam logic [DIMC_W-1:0] DIM_COUNT_RST = 3'd2;
  localparam logic [NUM_CUM-1:0][CUM_W-1:0] CUM_RST =
    {25'd65536, 25'd4096, 25'd256, 25'd16};

endpackage

// File: rtl/nd_grid_neighbour_enumerator_top.sv
// ---------------------------------------------------------------------------
// nd_grid_neighbour_enumerator_top
// Face neighbours of a linear cell index in a row-major N-dim grid.
// ---------------------------------------------------------------------------
// Path: an input beat passes the remainder stages, the serializer and the output register.
// Throughput: one result beat per cycle unless out_stall_i holds the output;
//   a cell with k kept neighbours gives k beats (up to 2 * dims, 8 at most).
// The per-dimension remainder runs through INDEX_BITS restoring stages.
// Reset: registers return to 2 dims and sizes 16/256/4096/65536, pipe empties.
`timescale 1ns / 1ps
`include "nd_grid_neighbour_enumerator_top_defines.svh"

module nd_grid_neighbour_enumerator_top #(
  parameter int unsigned MAX_DIMS   = 4,
  parameter int unsigned INDEX_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ndgn_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [ndgn_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [ndgn_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [INDEX_BITS-1:0]                 cell_index_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [INDEX_BITS-1:0]                 neighbour_index_o,
  output logic [1:0]                            neighbour_dim_o,
  output logic                                  upper_side_o,
  output logic                                  last_of_run_o
);

  localparam int unsigned CUM_W  = ndgn_pkg::CUM_W;
  localparam int unsigned DIMC_W = ndgn_pkg::DIMC_W;
  localparam int unsigned DW     = ndgn_pkg::APB_DATA_W;
  localparam int unsigned NLANE  = (MAX_DIMS < ndgn_pkg::NUM_CUM) ? MAX_DIMS
                                                                  : ndgn_pkg::NUM_CUM;
  localparam int unsigned NCAND  = 2 * NLANE;
  localparam int unsigned NSTG   = INDEX_BITS + 1;
  localparam int unsigned REM_W  = CUM_W;
  localparam int unsigned SUM_W  = ((INDEX_BITS > CUM_W) ? INDEX_BITS : CUM_W) + 1;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [DIMC_W-1:0]                          dim_count_q;
  logic [ndgn_pkg::NUM_CUM-1:0][CUM_W-1:0]    cum_q;
  logic                                       cfg_wr;
  ndgn_pkg::reg_idx_e                         cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_reg = ndgn_pkg::reg_idx_e'(paddr[ndgn_pkg::APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q <= ndgn_pkg::DIM_COUNT_RST;
      cum_q       <= ndgn_pkg::CUM_RST;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        ndgn_pkg::REG_DIM_COUNT: dim_count_q <= pwdata[DIMC_W-1:0];
        ndgn_pkg::REG_CUM_0:     cum_q[0]    <= pwdata[CUM_W-1:0];
        ndgn_pkg::REG_CUM_1:     cum_q[1]    <= pwdata[CUM_W-1:0];
        ndgn_pkg::REG_CUM_2:     cum_q[2]    <= pwdata[CUM_W-1:0];
        ndgn_pkg::REG_CUM_3:     cum_q[3]    <= pwdata[CUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_reg)
      ndgn_pkg::REG_DIM_COUNT: prdata = DW'(dim_count_q);
      ndgn_pkg::REG_CUM_0:     prdata = DW'(cum_q[0]);
      ndgn_pkg::REG_CUM_1:     prdata = DW'(cum_q[1]);
      ndgn_pkg::REG_CUM_2:     prdata = DW'(cum_q[2]);
      ndgn_pkg::REG_CUM_3:     prdata = DW'(cum_q[3]);
      default:                 prdata = '0;
    endcase
  end

  // Block size per lane (zero counts as one), step per lane, active lanes.
  logic [NLANE-1:0][CUM_W-1:0] blk_eff;
  logic [NLANE-1:0][CUM_W-1:0] lane_step;
  logic [NLANE-1:0]            lane_on;
  logic [DIMC_W-1:0]           dims_eff;

  always_comb begin
    dims_eff = (dim_count_q > DIMC_W'(NLANE)) ? DIMC_W'(NLANE) : dim_count_q;
    for (int l = 0; l < NLANE; l++) begin
      blk_eff[l] = (cum_q[l] == '0) ? CUM_W'(1) : cum_q[l];
      lane_on[l] = (DIMC_W'(l) < dims_eff);
    end
    lane_step[0] = CUM_W'(1);
    for (int l = 1; l < NLANE; l++) begin
      lane_step[l] = blk_eff[l-1];
    end
  end

  // -------------------------------------------------------------------------
  // Remainder pipeline: one restoring bit per stage, all lanes in parallel
  // -------------------------------------------------------------------------
  logic [NSTG-1:0]             s_valid_q;
  logic [INDEX_BITS-1:0]       s_idx_q [NSTG];
  logic [NLANE-1:0][REM_W-1:0] s_rem_q [NSTG];
  logic                        advance;
  logic                        ser_free;

  assign advance    = !s_valid_q[NSTG-1] || ser_free;
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= '0;
    end else if (advance) begin
      s_valid_q <= {s_valid_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s_idx_q[0] <= cell_index_i;
      s_rem_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < INDEX_BITS; k++) begin : g_div
    logic [NLANE-1:0][REM_W-1:0] rem_d;

    always_comb begin
      logic [REM_W:0] trial;
      for (int l = 0; l < NLANE; l++) begin
        trial = {s_rem_q[k][l], s_idx_q[k][INDEX_BITS-1-k]};
        if (trial >= {1'b0, blk_eff[l]}) begin
          trial = trial - {1'b0, blk_eff[l]};
        end
        rem_d[l] = trial[REM_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        s_idx_q[k+1] <= s_idx_q[k];
        s_rem_q[k+1] <= rem_d;
      end
    end
  end

  // Keep test on the full remainder r = idx mod blk:
  //   lower stays in block iff r >= step, upper iff r + step < blk and idx + step fits INDEX_BITS.
  logic [NCAND-1:0] cand_mask;

  always_comb begin
    logic [SUM_W-1:0] hi_sum;
    logic [SUM_W-1:0] r_sum;
    for (int l = 0; l < NLANE; l++) begin
      hi_sum = SUM_W'(s_idx_q[NSTG-1]) + SUM_W'(lane_step[l]);
      r_sum  = SUM_W'(s_rem_q[NSTG-1][l]) + SUM_W'(lane_step[l]);
      cand_mask[2*l]   = lane_on[l] && (s_rem_q[NSTG-1][l] >= lane_step[l]);
      cand_mask[2*l+1] = lane_on[l] && (hi_sum[SUM_W-1:INDEX_BITS] == '0)
                         && (r_sum < SUM_W'(blk_eff[l]));
    end
  end

  // -------------------------------------------------------------------------
  // Serializer: one kept neighbour per beat, lowest candidate first
  // -------------------------------------------------------------------------
  logic                  ser_busy_q, ser_busy_d;
  logic [NCAND-1:0]      ser_mask_q, ser_mask_d;
  logic [INDEX_BITS-1:0] ser_idx_q, ser_idx_d;
  logic [NCAND-1:0]      rest_mask;
  logic [CUM_W-1:0]      sel_step;
  logic [1:0]            sel_dim;
  logic                  sel_up;
  logic [SUM_W-1:0]      nb_sum;
  logic                  out_free;
  logic                  ser_emit;

  always_comb begin
    logic found;
    found     = 1'b0;
    rest_mask = ser_mask_q;
    sel_step  = lane_step[0];
    sel_dim   = '0;
    sel_up    = 1'b0;
    for (int p = 0; p < NCAND; p++) begin
      if (!found && ser_mask_q[p]) begin
        found        = 1'b1;
        rest_mask[p] = 1'b0;
        sel_step     = lane_step[p >> 1];
        sel_dim      = 2'(p >> 1);
        sel_up       = 1'((p & 1));
      end
    end
  end

  assign nb_sum   = sel_up ? SUM_W'(ser_idx_q) + SUM_W'(sel_step)
                           : SUM_W'(ser_idx_q) - SUM_W'(sel_step);
  assign out_free = !out_valid_o || !out_stall_i;
  assign ser_emit = ser_busy_q && out_free;
  assign ser_free = !ser_busy_q || (ser_emit && (rest_mask == '0));

  always_comb begin
    ser_busy_d = ser_busy_q;
    ser_mask_d = ser_mask_q;
    ser_idx_d  = ser_idx_q;
    if (ser_emit) begin
      ser_busy_d = |rest_mask;
      ser_mask_d = rest_mask;
    end
    // a cell with no kept neighbour is dropped here
    if (ser_free && s_valid_q[NSTG-1]) begin
      ser_busy_d = |cand_mask;
      ser_mask_d = cand_mask;
      ser_idx_d  = s_idx_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_busy_q <= 1'b0;
      ser_mask_q <= '0;
    end else begin
      ser_busy_q <= ser_busy_d;
      ser_mask_q <= ser_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ser_idx_q <= ser_idx_d;
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  logic                  out_valid_q;
  logic [INDEX_BITS-1:0] out_idx_q;
  logic [1:0]            out_dim_q;
  logic                  out_up_q;
  logic                  out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= ser_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_emit) begin
      out_idx_q  <= nb_sum[INDEX_BITS-1:0];
      out_dim_q  <= sel_dim;
      out_up_q   <= sel_up;
      out_last_q <= (rest_mask == '0);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign neighbour_index_o = out_idx_q;
  assign neighbour_dim_o   = out_dim_q;
  assign upper_side_o      = out_up_q;
  assign last_of_run_o     = out_last_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `NDGN_ASSERT_NEXT(a_stall_keeps_tail, s_valid_q[NSTG-1] && in_stall_o, s_valid_q[NSTG-1])
  `NDGN_ASSERT_IMPL(a_busy_has_work, ser_busy_q, ser_mask_q != '0)
  `NDGN_ASSERT_NEXT(a_ser_holds, ser_busy_q && !out_free, ser_busy_q && ser_mask_q == $past(ser_mask_q))

endmodule
